[hdl/cube_to_sphere_vertex_projector_defines.svh]
// Assertion macros for the cube to sphere vertex projector.
`ifndef CUBE_TO_SPHERE_VERTEX_PROJECTOR_DEFINES_SVH
`define CUBE_TO_SPHERE_VERTEX_PROJECTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define C2S_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c2s check failed");
`define C2S_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c2s check failed");
`else
`define C2S_ASSERT_IMP(lbl, ante, cons)
`define C2S_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hdl/c2s_pkg.sv]
// Types, face codes and saturation helpers for the cube to sphere projector.
package c2s_pkg;

    typedef enum logic [2:0] {
        FACE_UP    = 3'd0,
        FACE_DOWN  = 3'd1,
        FACE_FRONT = 3'd2,
        FACE_BACK  = 3'd3,
        FACE_RIGHT = 3'd4,
        FACE_LEFT  = 3'd5
    } t_face;

    localparam logic [2:0] FACE_CODES = 3'd6;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        NM_PASS  = 2'd0,
        NM_OWN   = 2'd1,
        NM_OTHER = 2'd2
    } t_nmode;

    typedef logic [2:0][15:0] t_vec3;

    localparam int SAT_W = 48;

    function automatic logic [1:0] face_axis(input logic [2:0] f);
        unique case (f)
            FACE_UP, FACE_DOWN:     return AXIS_Y;
            FACE_FRONT, FACE_BACK:  return AXIS_X;
            FACE_RIGHT, FACE_LEFT:  return AXIS_Z;
            default:                return AXIS_Y;
        endcase
    endfunction

    function automatic logic [1:0] face_other_a(input logic [2:0] f);
        unique case (f)
            FACE_UP, FACE_DOWN:     return AXIS_X;
            FACE_FRONT, FACE_BACK:  return AXIS_Y;
            FACE_RIGHT:             return AXIS_X;
            FACE_LEFT:              return AXIS_Y;
            default:                return AXIS_X;
        endcase
    endfunction

    function automatic logic [1:0] face_other_b(input logic [2:0] f);
        unique case (f)
            FACE_UP, FACE_DOWN:     return AXIS_Z;
            FACE_FRONT, FACE_BACK:  return AXIS_Z;
            FACE_RIGHT:             return AXIS_Y;
            FACE_LEFT:              return AXIS_X;
            default:                return AXIS_Z;
        endcase
    endfunction

    function automatic logic [15:0] sat_mag(input logic [SAT_W-1:0] q, input logic neg);
        logic [SAT_W-1:0] nq;
        nq = -q;
        if (neg) begin
            return (q > SAT_W'(32768)) ? 16'h8000 : nq[15:0];
        end
        return (q > SAT_W'(32767)) ? 16'h7fff : q[15:0];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [SAT_W-1:0] v);
        if (v > SAT_W'(32767)) begin
            return 16'h7fff;
        end
        if (v < -SAT_W'(32768)) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

endpackage

[hdl/cube_to_sphere_vertex_projector.sv]
// Cube to sphere vertex projector: pipelined chain of square root and divider cells.
//
// Input channel i_valid / o_ready carries one vertex (position and normal, signed
// fixed point with FRAC_BITS fraction bits). Output channel o_valid / i_ready
// returns one projected vertex per input item, in order.
// Configuration channel i_cfg_valid / o_cfg_ready writes cube_face; o_cfg_ready is
// always high. Write it only while no item is in flight.
// Each square root and each division is a row of cells settling one bit per
// cycle, so one item enters every cycle unless the pipeline is held.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_ready drops until that result is taken.
// Synchronous active low reset empties the pipeline and sets cube_face to up.
`include "cube_to_sphere_vertex_projector_defines.svh"
module cube_to_sphere_vertex_projector #(
    parameter int FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_pos_z,
    input  logic [15:0] i_norm_x,
    input  logic [15:0] i_norm_y,
    input  logic [15:0] i_norm_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_pos_x,
    output logic [15:0] o_out_pos_y,
    output logic [15:0] o_out_pos_z,
    output logic [15:0] o_out_norm_x,
    output logic [15:0] o_out_norm_y,
    output logic [15:0] o_out_norm_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);
    import c2s_pkg::*;

    localparam int SW  = (2 * FRAC_BITS + 2 > 32) ? 2 * FRAC_BITS + 2 : 32;
    localparam int WW  = SW / 2;
    localparam int NW  = (FRAC_BITS + 16 > 31) ? FRAC_BITS + 16 : 31;
    localparam int DNW = NW + 1;
    localparam int LSW = 32;
    localparam int LW  = 16;
    localparam int M2W = FRAC_BITS + 16;
    localparam int D2W = FRAC_BITS + 17;
    localparam int CW  = (FRAC_BITS + 3 > 17) ? FRAC_BITS + 3 : 17;
    localparam int VW  = 34;

    localparam logic signed [CW-1:0] HIT_LO = CW'(1) << FRAC_BITS;
    localparam logic signed [CW-1:0] HIT_HI = CW'(2) << FRAC_BITS;
    localparam logic [WW-1:0]        W_MIN  = WW'(1) << FRAC_BITS;
    localparam logic [31:0]          ROUND  = 32'(1) << (FRAC_BITS - 1);
    localparam logic signed [VW-1:0] ONE_V  = VW'(1) << FRAC_BITS;

    typedef struct packed {
        t_vec3                p;
        t_vec3                n;
        logic [2:0][NW-1:0]   mag;
        logic [2:0]           sgn;
    } t_sb1;

    typedef struct packed {
        t_vec3      p;
        t_vec3      n;
        logic [2:0] sgn;
    } t_sb2;

    typedef struct packed {
        t_vec3               p;
        t_vec3               n;
        t_vec3               rp;
        logic [2:0][M2W-1:0] mag;
        logic [2:0]          sgn;
    } t_sb3;

    typedef struct packed {
        t_vec3      p;
        t_vec3      n;
        t_vec3      rp;
        logic [2:0] sgn;
    } t_sb4;

    function automatic logic axis_hit(input logic [15:0] nv, input logic negd);
        logic signed [CW-1:0] d;
        d = CW'($signed(nv));
        if (negd) begin
            d = -d;
        end
        return (d >= HIT_LO) && (d < HIT_HI);
    endfunction

    logic       en;
    logic [2:0] r_face;
    logic [1:0] f_ax;
    logic [1:0] f_oa;
    logic [1:0] f_ob;
    logic       f_neg;
    logic       f_ok;

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face <= FACE_UP;
        end else if (i_cfg_valid) begin
            r_face <= i_cfg_data;
        end
    end

    assign f_ax  = face_axis(r_face);
    assign f_oa  = face_other_a(r_face);
    assign f_ob  = face_other_b(r_face);
    assign f_neg = r_face[0];
    assign f_ok  = (r_face < FACE_CODES);

    // input register
    logic  r0_v;
    t_vec3 r0_p;
    t_vec3 r0_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_p <= {i_pos_z, i_pos_y, i_pos_x};
            r0_n <= {i_norm_z, i_norm_y, i_norm_x};
        end
    end

    // squares and axis products
    logic signed [15:0] s1_a;
    logic [2:0][31:0]   n1_sq;
    logic [2:0][31:0]   n1_prod;
    logic               r1_v;
    t_vec3              r1_p;
    t_vec3              r1_n;
    logic [2:0][31:0]   r1_sq;
    logic [2:0][31:0]   r1_prod;

    assign s1_a = $signed(r0_p[f_ax]);

    for (genvar j = 0; j < 3; j++) begin : g_s1
        logic signed [15:0] pj;
        logic signed [31:0] sq;
        logic signed [31:0] pr;
        assign pj = $signed(r0_p[j]);
        assign sq = pj * pj;
        assign pr = s1_a * pj;
        assign n1_sq[j]   = sq;
        assign n1_prod[j] = pr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p    <= r0_p;
            r1_n    <= r0_n;
            r1_sq   <= n1_sq;
            r1_prod <= n1_prod;
        end
    end

    // radicand and dividend magnitudes
    logic signed [15:0] s2_a;
    logic [SW-1:0]      n2_s;
    t_sb1               n2_sb;
    logic               r2_v;
    logic [SW-1:0]      r2_s;
    t_sb1               r2_sb;

    assign s2_a = $signed(r1_p[f_ax]);

    always_comb begin
        n2_s = SW'(1) << (2 * FRAC_BITS);
        for (int j = 0; j < 3; j++) begin
            if (2'(j) != f_ax) begin
                n2_s = n2_s + SW'(r1_sq[j]);
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_s2
        logic signed [NW:0] num;
        logic signed [NW:0] neg_num;
        logic               on_ax;
        assign on_ax   = (2'(j) == f_ax);
        assign num     = on_ax ? ((NW+1)'(s2_a) <<< FRAC_BITS)
                               : (NW+1)'($signed(r1_prod[j]));
        assign neg_num = -num;
        assign n2_sb.mag[j] = num[NW] ? neg_num[NW-1:0] : num[NW-1:0];
        assign n2_sb.sgn[j] = num[NW] ^ (f_neg && !on_ax);
    end

    assign n2_sb.p = r1_p;
    assign n2_sb.n = r1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_s  <= n2_s;
            r2_sb <= n2_sb;
        end
    end

    // square root of the face radicand
    logic                    sq1_v    [0:WW];
    logic [SW-1:0]           sq1_rem  [0:WW];
    logic [SW-1:0]           sq1_root [0:WW];
    logic [$bits(t_sb1)-1:0] sq1_sb   [0:WW];

    assign sq1_v[0]    = r2_v;
    assign sq1_rem[0]  = r2_s;
    assign sq1_root[0] = '0;
    assign sq1_sb[0]   = r2_sb;

    for (genvar c = 0; c < WW; c++) begin : g_sq1
        c2s_sqrt_cell #(
            .SW   (SW),
            .STEP (WW - 1 - c),
            .SBW  ($bits(t_sb1))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_v     (sq1_v[c]),
            .i_rem   (sq1_rem[c]),
            .i_root  (sq1_root[c]),
            .i_sb    (sq1_sb[c]),
            .o_v     (sq1_v[c+1]),
            .o_rem   (sq1_rem[c+1]),
            .o_root  (sq1_root[c+1]),
            .o_sb    (sq1_sb[c+1])
        );
    end

    // rounded dividends for the projection
    t_sb1                s3_in;
    logic [WW-1:0]       s3_w;
    logic [2:0][DNW-1:0] n3_div;
    t_sb2                n3_sb;
    logic                r3_v;
    logic [WW-1:0]       r3_w;
    logic [2:0][DNW-1:0] r3_div;
    t_sb2                r3_sb;

    assign s3_in = sq1_sb[WW];
    assign s3_w  = sq1_root[WW][WW-1:0];

    for (genvar j = 0; j < 3; j++) begin : g_s3
        assign n3_div[j] = DNW'(s3_in.mag[j]) + DNW'(s3_w >> 1);
    end

    assign n3_sb.p   = s3_in.p;
    assign n3_sb.n   = s3_in.n;
    assign n3_sb.sgn = s3_in.sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= sq1_v[WW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_w   <= s3_w;
            r3_div <= n3_div;
            r3_sb  <= n3_sb;
        end
    end

    // projection divider
    logic                    dv1_v   [0:DNW];
    logic [WW-1:0]           dv1_den [0:DNW];
    logic [2:0][WW-1:0]      dv1_rem [0:DNW];
    logic [2:0][DNW-1:0]     dv1_acc [0:DNW];
    logic [$bits(t_sb2)-1:0] dv1_sb  [0:DNW];

    assign dv1_v[0]   = r3_v;
    assign dv1_den[0] = r3_w;
    assign dv1_rem[0] = '0;
    assign dv1_acc[0] = r3_div;
    assign dv1_sb[0]  = r3_sb;

    for (genvar c = 0; c < DNW; c++) begin : g_dv1
        c2s_div_cell #(
            .NW    (DNW),
            .DW    (WW),
            .LANES (3),
            .SBW   ($bits(t_sb2))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_v     (dv1_v[c]),
            .i_den   (dv1_den[c]),
            .i_rem   (dv1_rem[c]),
            .i_acc   (dv1_acc[c]),
            .i_sb    (dv1_sb[c]),
            .o_v     (dv1_v[c+1]),
            .o_den   (dv1_den[c+1]),
            .o_rem   (dv1_rem[c+1]),
            .o_acc   (dv1_acc[c+1]),
            .o_sb    (dv1_sb[c+1])
        );
    end

    // saturate projected position
    t_sb2  s4_in;
    t_vec3 n4_rp;
    logic  r4_v;
    t_vec3 r4_p;
    t_vec3 r4_n;
    t_vec3 r4_rp;

    assign s4_in = dv1_sb[DNW];

    for (genvar j = 0; j < 3; j++) begin : g_s4
        assign n4_rp[j] = sat_mag(SAT_W'(dv1_acc[DNW][j]), s4_in.sgn[j]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= dv1_v[DNW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_p  <= s4_in.p;
            r4_n  <= s4_in.n;
            r4_rp <= n4_rp;
        end
    end

    // squares of the projected position
    logic [2:0][31:0] n5_sq;
    logic             r5_v;
    t_vec3            r5_p;
    t_vec3            r5_n;
    t_vec3            r5_rp;
    logic [2:0][31:0] r5_sq;

    for (genvar j = 0; j < 3; j++) begin : g_s5
        logic signed [15:0] rj;
        logic signed [31:0] sq;
        assign rj = $signed(r4_rp[j]);
        assign sq = rj * rj;
        assign n5_sq[j] = sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_p  <= r4_p;
            r5_n  <= r4_n;
            r5_rp <= r4_rp;
            r5_sq <= n5_sq;
        end
    end

    // length radicand and normalize dividends
    logic [LSW-1:0] n6_l2;
    t_sb3           n6_sb;
    logic           r6_v;
    logic [LSW-1:0] r6_l2;
    t_sb3           r6_sb;

    assign n6_l2 = r5_sq[0] + r5_sq[1] + r5_sq[2];

    for (genvar j = 0; j < 3; j++) begin : g_s6
        logic [15:0] neg_r;
        logic [15:0] abs_r;
        assign neg_r = -r5_rp[j];
        assign abs_r = r5_rp[j][15] ? neg_r : r5_rp[j];
        assign n6_sb.mag[j] = M2W'(abs_r) << FRAC_BITS;
        assign n6_sb.sgn[j] = r5_rp[j][15];
    end

    assign n6_sb.p  = r5_p;
    assign n6_sb.n  = r5_n;
    assign n6_sb.rp = r5_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_l2 <= n6_l2;
            r6_sb <= n6_sb;
        end
    end

    // square root of the length
    logic                    sq2_v    [0:LW];
    logic [LSW-1:0]          sq2_rem  [0:LW];
    logic [LSW-1:0]          sq2_root [0:LW];
    logic [$bits(t_sb3)-1:0] sq2_sb   [0:LW];

    assign sq2_v[0]    = r6_v;
    assign sq2_rem[0]  = r6_l2;
    assign sq2_root[0] = '0;
    assign sq2_sb[0]   = r6_sb;

    for (genvar c = 0; c < LW; c++) begin : g_sq2
        c2s_sqrt_cell #(
            .SW   (LSW),
            .STEP (LW - 1 - c),
            .SBW  ($bits(t_sb3))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_v     (sq2_v[c]),
            .i_rem   (sq2_rem[c]),
            .i_root  (sq2_root[c]),
            .i_sb    (sq2_sb[c]),
            .o_v     (sq2_v[c+1]),
            .o_rem   (sq2_rem[c+1]),
            .o_root  (sq2_root[c+1]),
            .o_sb    (sq2_sb[c+1])
        );
    end

    // rounded dividends for the normalize
    t_sb3                s7_in;
    logic [LW-1:0]       s7_len;
    logic [2:0][D2W-1:0] n7_div;
    t_sb4                n7_sb;
    logic                r7_v;
    logic [LW-1:0]       r7_len;
    logic [2:0][D2W-1:0] r7_div;
    t_sb4                r7_sb;

    assign s7_in  = sq2_sb[LW];
    assign s7_len = sq2_root[LW][LW-1:0];

    for (genvar j = 0; j < 3; j++) begin : g_s7
        assign n7_div[j] = D2W'(s7_in.mag[j]) + D2W'(s7_len >> 1);
    end

    assign n7_sb.p   = s7_in.p;
    assign n7_sb.n   = s7_in.n;
    assign n7_sb.rp  = s7_in.rp;
    assign n7_sb.sgn = s7_in.sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= sq2_v[LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_len <= s7_len;
            r7_div <= n7_div;
            r7_sb  <= n7_sb;
        end
    end

    // normalize divider
    logic                    dv2_v   [0:D2W];
    logic [LW-1:0]           dv2_den [0:D2W];
    logic [2:0][LW-1:0]      dv2_rem [0:D2W];
    logic [2:0][D2W-1:0]     dv2_acc [0:D2W];
    logic [$bits(t_sb4)-1:0] dv2_sb  [0:D2W];

    assign dv2_v[0]   = r7_v;
    assign dv2_den[0] = r7_len;
    assign dv2_rem[0] = '0;
    assign dv2_acc[0] = r7_div;
    assign dv2_sb[0]  = r7_sb;

    for (genvar c = 0; c < D2W; c++) begin : g_dv2
        c2s_div_cell #(
            .NW    (D2W),
            .DW    (LW),
            .LANES (3),
            .SBW   ($bits(t_sb4))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_v     (dv2_v[c]),
            .i_den   (dv2_den[c]),
            .i_rem   (dv2_rem[c]),
            .i_acc   (dv2_acc[c]),
            .i_sb    (dv2_sb[c]),
            .o_v     (dv2_v[c+1]),
            .o_den   (dv2_den[c+1]),
            .o_rem   (dv2_rem[c+1]),
            .o_acc   (dv2_acc[c+1]),
            .o_sb    (dv2_sb[c+1])
        );
    end

    // saturate normalized position, zero length gives zero
    t_sb4  s8_in;
    logic  s8_zero;
    t_vec3 n8_nn;
    logic  r8_v;
    t_vec3 r8_p;
    t_vec3 r8_n;
    t_vec3 r8_rp;
    t_vec3 r8_nn;

    assign s8_in   = dv2_sb[D2W];
    assign s8_zero = (dv2_den[D2W] == '0);

    for (genvar j = 0; j < 3; j++) begin : g_s8
        assign n8_nn[j] = s8_zero ? 16'h0000
                                  : sat_mag(SAT_W'(dv2_acc[D2W][j]), s8_in.sgn[j]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= dv2_v[D2W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_p  <= s8_in.p;
            r8_n  <= s8_in.n;
            r8_rp <= s8_in.rp;
            r8_nn <= n8_nn;
        end
    end

    // axis tests and projection products
    t_nmode             s9_mode;
    logic [1:0]         s9_k;
    logic               s9_sgneg;
    logic signed [15:0] s9_nk;
    logic [2:0][31:0]   n9_t;
    logic               r9_v;
    t_nmode             r9_mode;
    logic [1:0]         r9_k;
    logic               r9_sgneg;
    logic [2:0][31:0]   r9_t;
    t_vec3              r9_p;
    t_vec3              r9_n;
    t_vec3              r9_rp;
    t_vec3              r9_nn;

    always_comb begin
        s9_mode  = NM_PASS;
        s9_k     = f_ax;
        s9_sgneg = 1'b0;
        priority if (axis_hit(r8_n[f_ax], f_neg)) begin
            s9_mode = NM_OWN;
        end else if (!f_neg) begin
            s9_mode = NM_PASS;
        end else if (axis_hit(r8_n[f_oa], 1'b0)) begin
            s9_mode = NM_OTHER;
            s9_k    = f_oa;
        end else if (axis_hit(r8_n[f_oa], 1'b1)) begin
            s9_mode  = NM_OTHER;
            s9_k     = f_oa;
            s9_sgneg = 1'b1;
        end else if (axis_hit(r8_n[f_ob], 1'b0)) begin
            s9_mode = NM_OTHER;
            s9_k    = f_ob;
        end else if (axis_hit(r8_n[f_ob], 1'b1)) begin
            s9_mode  = NM_OTHER;
            s9_k     = f_ob;
            s9_sgneg = 1'b1;
        end else begin
            s9_mode = NM_PASS;
        end
    end

    assign s9_nk = $signed(r8_nn[s9_k]);

    for (genvar j = 0; j < 3; j++) begin : g_s9
        logic signed [15:0] nj;
        logic signed [31:0] tp;
        assign nj = $signed(r8_nn[j]);
        assign tp = s9_nk * nj;
        assign n9_t[j] = tp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_mode  <= s9_mode;
            r9_k     <= s9_k;
            r9_sgneg <= s9_sgneg;
            r9_t     <= n9_t;
            r9_p     <= r8_p;
            r9_n     <= r8_n;
            r9_rp    <= r8_rp;
            r9_nn    <= r8_nn;
        end
    end

    // output register
    t_vec3 n10_p;
    t_vec3 n10_n;
    logic  r10_v;
    t_vec3 r10_p;
    t_vec3 r10_n;

    for (genvar j = 0; j < 3; j++) begin : g_s10
        logic [31:0]          neg_t;
        logic [31:0]          abs_t;
        logic [31:0]          m;
        logic signed [VW-1:0] proj;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] vs;
        logic [15:0]          rv;
        assign neg_t = -r9_t[j];
        assign abs_t = r9_t[j][31] ? neg_t : r9_t[j];
        assign m     = (abs_t + ROUND) >> FRAC_BITS;
        assign proj  = r9_t[j][31] ? -$signed(VW'(m)) : $signed(VW'(m));
        assign v     = ((2'(j) == r9_k) ? ONE_V : VW'(0)) - proj;
        assign vs    = r9_sgneg ? -v : v;
        assign rv    = sat16(SAT_W'(vs));

        always_comb begin
            n10_p[j] = f_ok ? r9_rp[j] : r9_p[j];
            n10_n[j] = r9_n[j];
            if (f_ok) begin
                unique case (r9_mode)
                    NM_OWN:   n10_n[j] = r9_nn[j];
                    NM_OTHER: n10_n[j] = rv;
                    NM_PASS:  n10_n[j] = r9_n[j];
                    default:  n10_n[j] = r9_n[j];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_p <= n10_p;
            r10_n <= n10_n;
        end
    end

    assign o_valid      = r10_v;
    assign o_out_pos_x  = r10_p[0];
    assign o_out_pos_y  = r10_p[1];
    assign o_out_pos_z  = r10_p[2];
    assign o_out_norm_x = r10_n[0];
    assign o_out_norm_y = r10_n[1];
    assign o_out_norm_z = r10_n[2];

    `C2S_ASSERT_NXT(a_accept_fill, i_valid && o_ready, r0_v)
    `C2S_ASSERT_IMP(a_w_floor, sq1_v[WW], sq1_root[WW][WW-1:0] >= W_MIN)
    `C2S_ASSERT_NXT(a_zero_len, en && dv2_v[D2W] && (dv2_den[D2W] == '0), r8_nn == '0)
    `C2S_ASSERT_NXT(a_hold_on_stall, r10_v && !i_ready, $stable(r9_v) && $stable(r9_t))

endmodule

[hdl/c2s_sqrt_cell.sv]
// One step of a pipelined integer square root: decides one root bit.
module c2s_sqrt_cell #(
    parameter int SW   = 32,
    parameter int STEP = 0,
    parameter int SBW  = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  logic [SW-1:0]  i_rem,
    input  logic [SW-1:0]  i_root,
    input  logic [SBW-1:0] i_sb,
    output logic           o_v,
    output logic [SW-1:0]  o_rem,
    output logic [SW-1:0]  o_root,
    output logic [SBW-1:0] o_sb
);

    localparam logic [SW-1:0] BIT = SW'(1) << (2 * STEP);

    logic [SW-1:0]  trial;
    logic           take;
    logic [SW-1:0]  n_rem;
    logic [SW-1:0]  n_root;
    logic           r_v;
    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_root;
    logic [SBW-1:0] r_sb;

    assign trial  = i_root + BIT;
    assign take   = (i_rem >= trial);
    assign n_rem  = take ? (i_rem - trial) : i_rem;
    assign n_root = take ? ((i_root >> 1) + BIT) : (i_root >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_sb   <= i_sb;
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_sb   = r_sb;

endmodule

[hdl/c2s_div_cell.sv]
// One step of a pipelined restoring divider over parallel lanes with a shared divisor.
module c2s_div_cell #(
    parameter int NW    = 32,
    parameter int DW    = 16,
    parameter int LANES = 3,
    parameter int SBW   = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_v,
    input  logic [DW-1:0]             i_den,
    input  logic [LANES-1:0][DW-1:0]  i_rem,
    input  logic [LANES-1:0][NW-1:0]  i_acc,
    input  logic [SBW-1:0]            i_sb,
    output logic                      o_v,
    output logic [DW-1:0]             o_den,
    output logic [LANES-1:0][DW-1:0]  o_rem,
    output logic [LANES-1:0][NW-1:0]  o_acc,
    output logic [SBW-1:0]            o_sb
);

    logic [LANES-1:0][DW-1:0] n_rem;
    logic [LANES-1:0][NW-1:0] n_acc;
    logic                     r_v;
    logic [DW-1:0]            r_den;
    logic [LANES-1:0][DW-1:0] r_rem;
    logic [LANES-1:0][NW-1:0] r_acc;
    logic [SBW-1:0]           r_sb;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [DW:0] part;
        logic [DW:0] diff;
        logic        take;
        assign part = {i_rem[l], i_acc[l][NW-1]};
        assign diff = part - {1'b0, i_den};
        assign take = (part >= {1'b0, i_den});
        assign n_rem[l] = take ? diff[DW-1:0] : part[DW-1:0];
        assign n_acc[l] = {i_acc[l][NW-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_sb  <= i_sb;
        end
    end

    assign o_v   = r_v;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_acc = r_acc;
    assign o_sb  = r_sb;

endmodule

[tb/tb_cube_to_sphere_vertex_projector.sv]
// Self-checking testbench for the cube to sphere vertex projector.
`timescale 1ns / 1ps
module tb_cube_to_sphere_vertex_projector;
    import c2s_pkg::*;

    localparam int FRAC = 12;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD = 400;

    typedef logic [5:0][15:0] t_vtx;

    class vertex_scoreboard;
        logic [2:0] face;
        t_vtx projected_q[$];
        int errors;
        int results_seen;

        function new();
            face = FACE_UP;
            errors = 0;
            results_seen = 0;
        endfunction

        function automatic longint sx(logic [15:0] v);
            return longint'($signed(v));
        endfunction

        function automatic logic [15:0] clip(longint v);
            if (v > 32767) return 16'h7fff;
            if (v < -32768) return 16'h8000;
            return v[15:0];
        endfunction

        function automatic longint unsigned root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic longint rdiv(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function automatic bit on_axis(longint comp, longint sg);
            longint d;
            d = comp * sg;
            return d >= ONE && d < 2 * ONE;
        endfunction

        function automatic t_vtx project(t_vtx vin);
            longint p[3], n[3], rp[3], rn[3], nn[3];
            int ax, oa, ob, k, c;
            bit neg, hit;
            longint a, w, len, sg, t, m, pr;
            longint unsigned s, l2;
            t_vtx r;
            for (int j = 0; j < 3; j++) begin
                p[j] = sx(vin[j]);
                n[j] = sx(vin[3 + j]);
                rp[j] = p[j];
                rn[j] = n[j];
            end
            if (face < FACE_CODES) begin
                case (face)
                    FACE_UP, FACE_DOWN: begin ax = 1; oa = 0; ob = 2; end
                    FACE_FRONT, FACE_BACK: begin ax = 0; oa = 1; ob = 2; end
                    FACE_RIGHT: begin ax = 2; oa = 0; ob = 1; end
                    default: begin ax = 2; oa = 1; ob = 0; end
                endcase
                neg = face[0];
                a = p[ax];
                s = 64'd1 << (2 * FRAC);
                for (int j = 0; j < 3; j++)
                    if (j != ax) s += longint'(p[j] * p[j]);
                w = longint'(root(s));
                for (int j = 0; j < 3; j++) begin
                    if (j == ax) begin
                        rp[j] = sx(clip(rdiv(a * ONE, w)));
                    end else begin
                        t = rdiv(a * p[j], w);
                        rp[j] = sx(clip(neg ? -t : t));
                    end
                end
                l2 = 0;
                for (int j = 0; j < 3; j++) l2 += longint'(rp[j] * rp[j]);
                len = longint'(root(l2));
                for (int j = 0; j < 3; j++)
                    nn[j] = (len == 0) ? 0 : sx(clip(rdiv(rp[j] * ONE, len)));
                if (on_axis(n[ax], neg ? -1 : 1)) begin
                    for (int j = 0; j < 3; j++) rn[j] = nn[j];
                end else if (neg) begin
                    hit = 0;
                    for (c = 0; c < 4 && !hit; c++) begin
                        k = (c < 2) ? oa : ob;
                        sg = c[0] ? -1 : 1;
                        if (on_axis(n[k], sg)) begin
                            hit = 1;
                            for (int j = 0; j < 3; j++) begin
                                t = nn[k] * nn[j];
                                m = (((t < 0) ? -t : t) + (ONE >> 1)) >>> FRAC;
                                pr = (t < 0) ? -m : m;
                                rn[j] = sx(clip(sg * (((j == k) ? ONE : 0) - pr)));
                            end
                        end
                    end
                end
            end
            for (int j = 0; j < 3; j++) begin
                r[j] = rp[j][15:0];
                r[3 + j] = rn[j][15:0];
            end
            return r;
        endfunction

        function void note_input(t_vtx vin);
            projected_q = {projected_q, project(vin)};
        endfunction

        function void check_result(t_vtx got);
            t_vtx want;
            string fname[6] = '{"pos_x", "pos_y", "pos_z", "norm_x", "norm_y", "norm_z"};
            results_seen++;
            if (projected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = projected_q.pop_front();
            for (int j = 0; j < 6; j++)
                if (want[j] !== got[j]) begin
                    $display("%0t: out_%s expected %h actual %h", $realtime, fname[j],
                             want[j], got[j]);
                    errors++;
                end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [15:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic [15:0] i_norm_x = 0, i_norm_y = 0, i_norm_z = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [15:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic [15:0] o_out_norm_x, o_out_norm_y, o_out_norm_z;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = 0;

    vertex_scoreboard sb = new();
    int  idle_run = 0;
    int  sent = 0;
    bit  no_gaps = 0;
    bit  hold_req = 0;

    cube_to_sphere_vertex_projector #(.FRAC_BITS(FRAC)) u_top (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.face = i_cfg_data;
            if (i_valid && o_ready)
                sb.note_input({i_norm_z, i_norm_y, i_norm_x, i_pos_z, i_pos_y, i_pos_x});
            if (o_valid && i_ready)
                sb.check_result({o_out_norm_z, o_out_norm_y, o_out_norm_x,
                                 o_out_pos_z, o_out_pos_y, o_out_pos_x});
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("%0t: timeout with %0d results outstanding", $realtime,
                         sb.projected_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: random wait before each item, one long hold on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 0;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 5);
                if (gap > 0) begin
                    i_ready = 0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_ready = 1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_vertex(t_vtx v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        {i_norm_z, i_norm_y, i_norm_x, i_pos_z, i_pos_y, i_pos_x} = v;
        i_valid = 1;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 0;
        while (sb.projected_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_face(logic [2:0] f);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_data = f;
        i_cfg_valid = 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    function automatic logic [15:0] axis_comp();
        logic [15:0] m;
        m = 16'($urandom_range(4096, 8191));
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    function automatic t_vtx random_vertex();
        t_vtx v;
        int k;
        if ($urandom_range(0, 9) < 4) begin
            for (int j = 0; j < 6; j++) v[j] = 16'($urandom);
        end else begin
            for (int j = 0; j < 3; j++)
                v[j] = 16'($signed($urandom_range(0, 16383)) - 8192);
            for (int j = 3; j < 6; j++)
                v[j] = 16'($signed($urandom_range(0, 8191)) - 4096);
            k = $urandom_range(0, 2);
            v[3 + k] = axis_comp();
            if ($urandom_range(0, 7) == 0) v[3 + k] = $urandom_range(0, 1) ? 16'h2000 : 16'h0fff;
            if ($urandom_range(0, 15) == 0) v[2:0] = '0;
        end
        return v;
    endfunction

    t_vtx directed [3] = '{
        {16'h0000, 16'h1000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff},
        {16'hf000, 16'h0000, 16'h1fff, 16'h8000, 16'h7fff, 16'h0000},
        {16'h0000, 16'he001, 16'h1000, 16'h0000, 16'h0000, 16'h0000}
    };

    initial begin
        logic [2:0] f;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes and axis normals under every face code
        for (int fc = 0; fc < 8; fc++) begin
            write_face(3'(fc));
            for (int d = 0; d < 3; d++) send_vertex(directed[d]);
        end

        for (int ph = 0; ph < 10; ph++) begin
            f = (ph == 0) ? FACE_DOWN : (ph == 1) ? FACE_LEFT :
                ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
            write_face(f);
            no_gaps = (ph == 3);
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 150; n++) begin
                if (ph == 5 && n == 75) wait_drained();
                send_vertex(random_vertex());
            end
        end
        no_gaps = 0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d vertices, checked %0d results, %0d mismatches", sent,
                 sb.results_seen, sb.errors);
        $display("faces 0..7 written, long output hold and input drain pause exercised");
        if (sb.errors == 0 && sb.projected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/c2s_pkg.sv
hdl/c2s_sqrt_cell.sv
hdl/c2s_div_cell.sv
hdl/cube_to_sphere_vertex_projector.sv
tb/tb_cube_to_sphere_vertex_projector.sv
